// File: hdl/pst_pkg.sv
// Package for the spanning tree core: sizes, widths and the structs
// passed between the sequencer and the row scan unit. No dependencies.
package pst_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VBITS        = $clog2(MAX_VERTICES);
    localparam int CBITS        = 6;
    localparam int WBITS        = 16;
    localparam int ABITS        = 2 * VBITS;
    localparam int MEM_DEPTH    = MAX_VERTICES * MAX_VERTICES;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    typedef struct packed {
        logic             clear_all;
        logic             mark;
        logic [VBITS-1:0] mark_vertex;
        logic             round_start;
        logic             proc;
        logic [VBITS-1:0] proc_j;
        logic [VBITS-1:0] u;
        logic [VBITS-1:0] pos;
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [WBITS-1:0] w;
        logic [VBITS-1:0] from_v;
        logic [VBITS-1:0] to_v;
    } scan_res_t;

endpackage

// File: hdl/pst_wmem.sv
// Adjacency matrix storage: one write port, one registered read port.
// Sweeps every entry to zero after reset. Depends on pst_pkg.
module pst_wmem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      we,
    input  logic [pst_pkg::ABITS-1:0] waddr,
    input  logic [pst_pkg::WBITS-1:0] wdata,
    input  logic [pst_pkg::ABITS-1:0] raddr,
    output logic [pst_pkg::WBITS-1:0] rdata,
    output logic                      clear_busy
);

    logic [pst_pkg::WBITS-1:0] mem [pst_pkg::MEM_DEPTH];
    logic [pst_pkg::ABITS:0]   clr_cnt_reg;
    logic [pst_pkg::ABITS:0]   clr_cnt_next;
    logic                      m_we;
    logic [pst_pkg::ABITS-1:0] m_addr;
    logic [pst_pkg::WBITS-1:0] m_data;

    assign clear_busy   = (clr_cnt_reg != (pst_pkg::ABITS+1)'(pst_pkg::MEM_DEPTH));
    assign clr_cnt_next = clear_busy ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign m_we         = clear_busy || we;
    assign m_addr       = clear_busy ? clr_cnt_reg[pst_pkg::ABITS-1:0] : waddr;
    assign m_data       = clear_busy ? '0 : wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mem[m_addr] <= m_data;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/pst_scan.sv
// Row scan unit: keeps tree membership and the cheapest known link of each
// outside vertex, and picks the best link during a row scan. Depends on pst_pkg.
module pst_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pst_pkg::scan_ctl_t        ctl,
    input  logic [pst_pkg::WBITS-1:0] rdata,
    output pst_pkg::scan_res_t        res
);

    logic [pst_pkg::MAX_VERTICES-1:0] in_tree_reg, in_tree_next;
    logic [pst_pkg::MAX_VERTICES-1:0] kv_reg, kv_next;
    logic [pst_pkg::WBITS-1:0]        key_w_reg    [pst_pkg::MAX_VERTICES];
    logic [pst_pkg::VBITS-1:0]        key_pos_reg  [pst_pkg::MAX_VERTICES];
    logic [pst_pkg::VBITS-1:0]        key_from_reg [pst_pkg::MAX_VERTICES];
    logic                             best_found_reg, best_found_next;
    logic [pst_pkg::WBITS-1:0]        best_w_reg, best_w_next;
    logic [pst_pkg::VBITS-1:0]        best_pos_reg, best_pos_next;
    logic [pst_pkg::VBITS-1:0]        best_from_reg, best_from_next;
    logic [pst_pkg::VBITS-1:0]        best_to_reg, best_to_next;
    logic                             outside;
    logic                             upd;
    logic                             eff_v;
    logic [pst_pkg::WBITS-1:0]        eff_w;
    logic [pst_pkg::VBITS-1:0]        eff_pos;
    logic [pst_pkg::VBITS-1:0]        eff_from;
    logic                             better;

    always_comb
    begin
        outside  = !in_tree_reg[ctl.proc_j];
        upd      = ctl.proc && outside && (rdata != '0)
                   && (!kv_reg[ctl.proc_j] || rdata < key_w_reg[ctl.proc_j]);
        eff_v    = ctl.proc && outside && (kv_reg[ctl.proc_j] || upd);
        eff_w    = upd ? rdata : key_w_reg[ctl.proc_j];
        eff_pos  = upd ? ctl.pos : key_pos_reg[ctl.proc_j];
        eff_from = upd ? ctl.u : key_from_reg[ctl.proc_j];
        better   = eff_v && (!best_found_reg || eff_w < best_w_reg
                   || (eff_w == best_w_reg && eff_pos < best_pos_reg));

        in_tree_next = ctl.clear_all ? '0 : in_tree_reg;
        kv_next      = ctl.clear_all ? '0 : kv_reg;
        if (ctl.mark)
        begin
            in_tree_next[ctl.mark_vertex] = 1'b1;
        end
        if (upd)
        begin
            kv_next[ctl.proc_j] = 1'b1;
        end

        best_found_next = best_found_reg;
        best_w_next     = best_w_reg;
        best_pos_next   = best_pos_reg;
        best_from_next  = best_from_reg;
        best_to_next    = best_to_reg;
        if (ctl.round_start)
        begin
            best_found_next = 1'b0;
        end
        else if (better)
        begin
            best_found_next = 1'b1;
            best_w_next     = eff_w;
            best_pos_next   = eff_pos;
            best_from_next  = eff_from;
            best_to_next    = ctl.proc_j;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tree_reg    <= '0;
            kv_reg         <= '0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            in_tree_reg    <= in_tree_next;
            kv_reg         <= kv_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_w_reg    <= best_w_next;
        best_pos_reg  <= best_pos_next;
        best_from_reg <= best_from_next;
        best_to_reg   <= best_to_next;
        if (upd)
        begin
            key_w_reg[ctl.proc_j]    <= rdata;
            key_pos_reg[ctl.proc_j]  <= ctl.pos;
            key_from_reg[ctl.proc_j] <= ctl.u;
        end
    end

    assign res.found  = best_found_reg;
    assign res.w      = best_w_reg;
    assign res.from_v = best_from_reg;
    assign res.to_v   = best_to_reg;

    a_best_outside: assert property (@(posedge clk) disable iff (!rst_n)
        best_found_reg && ctl.proc |-> !in_tree_reg[best_to_reg])
        else $error("best link points into the tree");
    a_no_upd_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> !in_tree_reg[ctl.proc_j])
        else $error("key updated for a tree vertex");
    a_mark_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mark && !ctl.clear_all |=> in_tree_reg[$past(ctl.mark_vertex)])
        else $error("marked vertex missing from tree");

endmodule

// File: hdl/prim_spanning_tree_from_source_core.sv
// Minimum spanning tree core: adjacency matrix, sequencer and output register.
// Depends on pst_pkg, pst_wmem and pst_scan.
// A valid edge write stores both matrix entries. A run emits the start vertex,
// then each added edge, or one bad_start result for an out-of-range start;
// each added vertex costs a scan of its matrix row in S_SCAN, then S_DRAIN,
// S_DECIDE and S_EMIT, where a stalled output waits. No transaction is
// taken during a run. After reset the matrix is cleared one entry per cycle,
// all 1024 entries, before any transaction; config writes are taken then.
module prim_spanning_tree_from_source_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [pst_pkg::CBITS-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [pst_pkg::VBITS-1:0] first_vertex,
    input  logic [pst_pkg::VBITS-1:0] second_vertex,
    input  logic [pst_pkg::WBITS-1:0] weight,
    input  logic [pst_pkg::VBITS-1:0] start_vertex,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [pst_pkg::VBITS-1:0] from_vertex,
    output logic [pst_pkg::VBITS-1:0] to_vertex,
    output logic [pst_pkg::WBITS-1:0] edge_weight,
    output logic                      has_edge,
    output logic                      bad_start,
    output logic                      last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR2,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [pst_pkg::CBITS-1:0] vc_reg;
    logic [pst_pkg::CBITS-1:0] n;
    logic [pst_pkg::VBITS-1:0] u_reg, u_next;
    logic [pst_pkg::VBITS-1:0] pos_reg, pos_next;
    logic [pst_pkg::CBITS-1:0] size_reg, size_next;
    logic [pst_pkg::CBITS-1:0] j_reg, j_next;
    logic                      rd_v_reg, rd_v_next;
    logic [pst_pkg::VBITS-1:0] rd_j_reg, rd_j_next;
    logic                      finish_reg, finish_next;
    logic [pst_pkg::VBITS-1:0] wa_reg, wa_next;
    logic [pst_pkg::VBITS-1:0] wb_reg, wb_next;
    logic [pst_pkg::WBITS-1:0] ww_reg, ww_next;
    logic [pst_pkg::VBITS-1:0] p_from_reg, p_from_next;
    logic [pst_pkg::VBITS-1:0] p_to_reg, p_to_next;
    logic [pst_pkg::WBITS-1:0] p_w_reg, p_w_next;
    logic                      p_has_reg, p_has_next;
    logic                      ov_reg, ov_next;
    logic [pst_pkg::VBITS-1:0] o_from_reg, o_from_next;
    logic [pst_pkg::VBITS-1:0] o_to_reg, o_to_next;
    logic [pst_pkg::WBITS-1:0] o_w_reg, o_w_next;
    logic                      o_has_reg, o_has_next;
    logic                      o_bad_reg, o_bad_next;
    logic                      o_last_reg, o_last_next;
    logic                      accept;
    logic                      clear_busy;
    logic                      m_we;
    logic [pst_pkg::ABITS-1:0] m_waddr;
    logic [pst_pkg::WBITS-1:0] m_wdata;
    logic [pst_pkg::ABITS-1:0] m_raddr;
    logic [pst_pkg::WBITS-1:0] m_rdata;
    pst_pkg::scan_ctl_t        sctl;
    pst_pkg::scan_res_t        sres;

    assign n = (vc_reg > pst_pkg::CBITS'(pst_pkg::MAX_VERTICES))
               ? pst_pkg::CBITS'(pst_pkg::MAX_VERTICES) : vc_reg;
    assign in_stall = !(state_reg == S_IDLE && !clear_busy);
    assign accept   = in_valid && !in_stall;

    pst_wmem u_wmem (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (m_we),
        .waddr      (m_waddr),
        .wdata      (m_wdata),
        .raddr      (m_raddr),
        .rdata      (m_rdata),
        .clear_busy (clear_busy)
    );

    pst_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sctl),
        .rdata (m_rdata),
        .res   (sres)
    );

    always_comb
    begin
        state_next  = state_reg;
        u_next      = u_reg;
        pos_next    = pos_reg;
        size_next   = size_reg;
        j_next      = j_reg;
        rd_v_next   = 1'b0;
        rd_j_next   = j_reg[pst_pkg::VBITS-1:0];
        finish_next = finish_reg;
        wa_next     = wa_reg;
        wb_next     = wb_reg;
        ww_next     = ww_reg;
        p_from_next = p_from_reg;
        p_to_next   = p_to_reg;
        p_w_next    = p_w_reg;
        p_has_next  = p_has_reg;
        ov_next     = ov_reg;
        o_from_next = o_from_reg;
        o_to_next   = o_to_reg;
        o_w_next    = o_w_reg;
        o_has_next  = o_has_reg;
        o_bad_next  = o_bad_reg;
        o_last_next = o_last_reg;
        m_we        = 1'b0;
        m_waddr     = {first_vertex, second_vertex};
        m_wdata     = weight;
        m_raddr     = {u_reg, j_reg[pst_pkg::VBITS-1:0]};
        sctl        = '0;
        sctl.proc   = rd_v_reg;
        sctl.proc_j = rd_j_reg;
        sctl.u      = u_reg;
        sctl.pos    = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == pst_pkg::KIND_WRITE)
                    begin
                        if (weight != '0 && pst_pkg::CBITS'(first_vertex) < n
                            && pst_pkg::CBITS'(second_vertex) < n)
                        begin
                            m_we       = 1'b1;
                            wa_next    = second_vertex;
                            wb_next    = first_vertex;
                            ww_next    = weight;
                            state_next = S_WR2;
                        end
                    end
                    else if (pst_pkg::CBITS'(start_vertex) >= n)
                    begin
                        o_from_next = '0;
                        o_to_next   = start_vertex;
                        o_w_next    = '0;
                        o_has_next  = 1'b0;
                        o_bad_next  = 1'b1;
                        o_last_next = 1'b1;
                        ov_next     = 1'b1;
                        finish_next = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        sctl.clear_all   = 1'b1;
                        sctl.mark        = 1'b1;
                        sctl.mark_vertex = start_vertex;
                        p_from_next      = start_vertex;
                        p_to_next        = start_vertex;
                        p_w_next         = '0;
                        p_has_next       = 1'b0;
                        u_next           = start_vertex;
                        pos_next         = '0;
                        size_next        = pst_pkg::CBITS'(1);
                        j_next           = '0;
                        if (n > pst_pkg::CBITS'(1))
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            o_from_next = start_vertex;
                            o_to_next   = start_vertex;
                            o_w_next    = '0;
                            o_has_next  = 1'b0;
                            o_bad_next  = 1'b0;
                            o_last_next = 1'b1;
                            ov_next     = 1'b1;
                            finish_next = 1'b1;
                            state_next  = S_EMIT;
                        end
                    end
                end
            end
            S_WR2:
            begin
                m_we       = 1'b1;
                m_waddr    = {wa_reg, wb_reg};
                m_wdata    = ww_reg;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                sctl.round_start = (j_reg == '0);
                rd_v_next        = 1'b1;
                j_next           = j_reg + 1'b1;
                if (j_next == n)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                o_from_next = p_from_reg;
                o_to_next   = p_to_reg;
                o_w_next    = p_w_reg;
                o_has_next  = p_has_reg;
                o_bad_next  = 1'b0;
                ov_next     = 1'b1;
                state_next  = S_EMIT;
                if (sres.found)
                begin
                    o_last_next      = 1'b0;
                    finish_next      = 1'b0;
                    sctl.mark        = 1'b1;
                    sctl.mark_vertex = sres.to_v;
                    p_from_next      = sres.from_v;
                    p_to_next        = sres.to_v;
                    p_w_next         = sres.w;
                    p_has_next       = 1'b1;
                    u_next           = sres.to_v;
                    pos_next         = pos_reg + 1'b1;
                    size_next        = size_reg + 1'b1;
                end
                else
                begin
                    o_last_next = 1'b1;
                    finish_next = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    if (finish_reg)
                    begin
                        ov_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (size_reg < n)
                    begin
                        ov_next    = 1'b0;
                        j_next     = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        o_from_next = p_from_reg;
                        o_to_next   = p_to_reg;
                        o_w_next    = p_w_reg;
                        o_has_next  = p_has_reg;
                        o_bad_next  = 1'b0;
                        o_last_next = 1'b1;
                        finish_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vc_reg     <= '0;
            rd_v_reg   <= 1'b0;
            finish_reg <= 1'b0;
            ov_reg     <= 1'b0;
            size_reg   <= '0;
            j_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_v_reg   <= rd_v_next;
            finish_reg <= finish_next;
            ov_reg     <= ov_next;
            size_reg   <= size_next;
            j_reg      <= j_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        pos_reg    <= pos_next;
        rd_j_reg   <= rd_j_next;
        wa_reg     <= wa_next;
        wb_reg     <= wb_next;
        ww_reg     <= ww_next;
        p_from_reg <= p_from_next;
        p_to_reg   <= p_to_next;
        p_w_reg    <= p_w_next;
        p_has_reg  <= p_has_next;
        o_from_reg <= o_from_next;
        o_to_reg   <= o_to_next;
        o_w_reg    <= o_w_next;
        o_has_reg  <= o_has_next;
        o_bad_reg  <= o_bad_next;
        o_last_reg <= o_last_next;
    end

    assign out_valid   = ov_reg;
    assign from_vertex = o_from_reg;
    assign to_vertex   = o_to_reg;
    assign edge_weight = o_w_reg;
    assign has_edge    = o_has_reg;
    assign bad_start   = o_bad_reg;
    assign last        = o_last_reg;

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> in_stall)
        else $error("transaction taken during matrix clear");
    a_edge_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_edge |-> !bad_start)
        else $error("edge result flagged as bad start");
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_start |-> last)
        else $error("bad start result not final");
    a_scan_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> size_reg < n)
        else $error("scan with a full tree");

endmodule

// File: tb/tb_prim_spanning_tree_from_source_core.sv
// Self-checking testbench for the Prim spanning tree core: drives edge writes
// and runs, predicts each tree result and compares it with the block output.
// Depends on pst_pkg and prim_spanning_tree_from_source_core.
`timescale 1ns / 1ps

module tb_prim_spanning_tree_from_source_core;

    typedef struct packed {
        logic [pst_pkg::VBITS-1:0] from_v;
        logic [pst_pkg::VBITS-1:0] to_v;
        logic [pst_pkg::WBITS-1:0] w;
        logic                      has;
        logic                      bad;
        logic                      lst;
    } tree_res_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [pst_pkg::CBITS-1:0] cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind = pst_pkg::KIND_WRITE;
    logic [pst_pkg::VBITS-1:0] first_vertex = '0;
    logic [pst_pkg::VBITS-1:0] second_vertex = '0;
    logic [pst_pkg::WBITS-1:0] weight = '0;
    logic [pst_pkg::VBITS-1:0] start_vertex = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [pst_pkg::VBITS-1:0] from_vertex;
    logic [pst_pkg::VBITS-1:0] to_vertex;
    logic [pst_pkg::WBITS-1:0] edge_weight;
    logic                      has_edge;
    logic                      bad_start;
    logic                      last;

    logic [pst_pkg::WBITS-1:0] adj [pst_pkg::MAX_VERTICES][pst_pkg::MAX_VERTICES];
    logic [pst_pkg::CBITS-1:0] vcount;
    tree_res_t                 pending_results[$];
    int                        error_count = 0;
    int                        hold_cycles = 0;
    bit                        rx_random = 1'b1;

    always #10 clk = ~clk;

    prim_spanning_tree_from_source_core i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .first_vertex(first_vertex), .second_vertex(second_vertex),
        .weight(weight), .start_vertex(start_vertex), .out_valid(out_valid),
        .out_stall(out_stall), .from_vertex(from_vertex), .to_vertex(to_vertex),
        .edge_weight(edge_weight), .has_edge(has_edge), .bad_start(bad_start),
        .last(last)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_expected(input tree_res_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic grow_tree(input logic k, input logic [pst_pkg::VBITS-1:0] a,
                             input logic [pst_pkg::VBITS-1:0] b,
                             input logic [pst_pkg::WBITS-1:0] w,
                             input logic [pst_pkg::VBITS-1:0] s);
        int n;
        int sz;
        bit joined [pst_pkg::MAX_VERTICES];
        int order [pst_pkg::MAX_VERTICES];
        bit found;
        int bf;
        int bt;
        logic [pst_pkg::WBITS-1:0] best;
        tree_res_t r;
        n = (int'(vcount) > pst_pkg::MAX_VERTICES) ? pst_pkg::MAX_VERTICES
                                                   : int'(vcount);
        if (k == pst_pkg::KIND_WRITE)
        begin
            if (w != 0 && int'(a) < n && int'(b) < n)
            begin
                adj[a][b] = w;
                adj[b][a] = w;
            end
            return;
        end
        if (int'(s) >= n)
        begin
            r = '{from_v: '0, to_v: s, w: '0, has: 1'b0, bad: 1'b1, lst: 1'b1};
            add_expected(r);
            return;
        end
        foreach (joined[i])
            joined[i] = 1'b0;
        joined[s] = 1'b1;
        order[0] = int'(s);
        sz = 1;
        r = '{from_v: s, to_v: s, w: '0, has: 1'b0, bad: 1'b0, lst: 1'b0};
        add_expected(r);
        while (sz < n)
        begin
            found = 1'b0;
            best = '0;
            bf = 0;
            bt = 0;
            for (int i = 0; i < sz; i++)
                for (int j = 0; j < n; j++)
                    if (adj[order[i]][j] != 0 && !joined[j]
                        && (!found || adj[order[i]][j] < best))
                    begin
                        found = 1'b1;
                        best = adj[order[i]][j];
                        bf = order[i];
                        bt = j;
                    end
            if (!found)
                break;
            joined[bt] = 1'b1;
            order[sz] = bt;
            sz++;
            r = '{from_v: pst_pkg::VBITS'(bf), to_v: pst_pkg::VBITS'(bt), w: best,
                  has: 1'b1, bad: 1'b0, lst: 1'b0};
            add_expected(r);
        end
        pending_results[$].lst = 1'b1;
    endtask

    task automatic send_item(input logic k, input int a, input int b, input int w,
                             input int s);
        int g;
        logic [pst_pkg::VBITS-1:0] a_v;
        logic [pst_pkg::VBITS-1:0] b_v;
        logic [pst_pkg::WBITS-1:0] w_v;
        logic [pst_pkg::VBITS-1:0] s_v;
        a_v = pst_pkg::VBITS'(a);
        b_v = pst_pkg::VBITS'(b);
        w_v = pst_pkg::WBITS'(w);
        s_v = pst_pkg::VBITS'(s);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        first_vertex <= a_v;
        second_vertex <= b_v;
        weight <= w_v;
        start_vertex <= s_v;
        do
            @(posedge clk);
        while (in_stall);
        grow_tree(k, a_v, b_v, w_v, s_v);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (1200) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int n);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= pst_pkg::CBITS'(n);
        @(posedge clk);
        cfg_we <= 1'b0;
        vcount = pst_pkg::CBITS'(n);
    endtask

    task automatic test_reset_empty();
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 0);
        set_vertex_count(1);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 0);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 31);
    endtask

    task automatic test_directed();
        set_vertex_count(5);
        send_item(pst_pkg::KIND_WRITE, 0, 1, 16'hFFFF, 0);
        send_item(pst_pkg::KIND_WRITE, 1, 2, 16'd1, 0);
        send_item(pst_pkg::KIND_WRITE, 0, 2, 16'd1, 0);
        send_item(pst_pkg::KIND_WRITE, 3, 3, 16'd2, 0);
        send_item(pst_pkg::KIND_WRITE, 3, 4, 16'd0, 0);
        send_item(pst_pkg::KIND_WRITE, 4, 31, 16'd7, 0);
        send_item(pst_pkg::KIND_WRITE, 2, 3, 16'd1, 0);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 0);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 4);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 5);
        set_vertex_count(3);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 2);
        set_vertex_count(63);
        send_item(pst_pkg::KIND_WRITE, 31, 30, 16'h8000, 0);
        send_item(pst_pkg::KIND_WRITE, 5, 31, 16'h7FFF, 0);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 31);
        set_vertex_count(32);
        send_item(pst_pkg::KIND_RUN, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int items);
        int n;
        int r;
        int a;
        int b;
        for (int i = 0; i < items; i++)
        begin
            if (i % 45 == 0)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 63)
                                                : $urandom_range(0, 12);
                set_vertex_count(n);
            end
            n = (int'(vcount) > pst_pkg::MAX_VERTICES) ? pst_pkg::MAX_VERTICES
                                                       : int'(vcount);
            r = $urandom_range(0, 99);
            if (r < 80 && n > 0)
            begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                send_item(pst_pkg::KIND_WRITE, a, b,
                          ($urandom_range(0, 1) != 0) ? $urandom_range(1, 20)
                                                      : $urandom(), 0);
            end
            else if (r < 85)
                send_item(pst_pkg::KIND_WRITE, $urandom(), $urandom(), $urandom(),
                          $urandom());
            else
                send_item(pst_pkg::KIND_RUN, $urandom(), $urandom(), $urandom(),
                          ($urandom_range(0, 4) == 0 || n == 0)
                              ? $urandom() : $urandom_range(0, n - 1));
        end
    endtask

    task automatic test_backpressure();
        set_vertex_count(8);
        rx_random = 1'b0;
        hold_cycles = 3000;
        for (int i = 0; i < 4; i++)
            send_item(pst_pkg::KIND_RUN, 0, 0, 0, i);
        rx_random = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (rx_random)
            out_stall <= ($urandom_range(0, 99) < 20) ? 1'b1
                       : ($urandom_range(0, 199) == 0);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        tree_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction to_vertex=%0d", to_vertex);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (from_vertex !== e.from_v)
                begin
                    $error("from_vertex exp %0d got %0d", e.from_v, from_vertex);
                    error_count++;
                end
                if (to_vertex !== e.to_v)
                begin
                    $error("to_vertex exp %0d got %0d", e.to_v, to_vertex);
                    error_count++;
                end
                if (edge_weight !== e.w)
                begin
                    $error("edge_weight exp %0d got %0d", e.w, edge_weight);
                    error_count++;
                end
                if (has_edge !== e.has)
                begin
                    $error("has_edge exp %0d got %0d", e.has, has_edge);
                    error_count++;
                end
                if (bad_start !== e.bad)
                begin
                    $error("bad_start exp %0d got %0d", e.bad, bad_start);
                    error_count++;
                end
                if (last !== e.lst)
                begin
                    $error("last exp %0d got %0d", e.lst, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        foreach (adj[i, j])
            adj[i][j] = '0;
        vcount = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_empty();
        test_directed();
        test_backpressure();
        test_random(155);
        drain();
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_prim_spanning_tree_from_source_core: done, clean");
        else
            $display("tb_prim_spanning_tree_from_source_core: done, errors");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("tb_prim_spanning_tree_from_source_core: done, errors");
        $finish;
    end

endmodule
